// ===== rtl/air_sensor_frame_finder_top_macros.svh =====
// Assertion macros for the frame finder checks.
`ifndef AIR_SENSOR_FRAME_FINDER_TOP_MACROS_SVH
`define AIR_SENSOR_FRAME_FINDER_TOP_MACROS_SVH

// Clocked check, masked while reset is high.
`define ASFF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("frame finder check failed");

// Clocked check that also holds during reset.
`define ASFF_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("frame finder check failed");

`endif

// ===== rtl/asff_pkg.sv =====
package asff_pkg;

   localparam int FrameLen = 12;
   localparam logic [5:0] FRAME_LEN_CNT = 6'd12;
   localparam logic [5:0] BURST_DEPTH = 6'd32;
   localparam logic [5:0] COUNT_MAX = 6'd63;
   localparam logic [7:0] FRAME_HEADER = 8'h2C;
   localparam int FieldBits = 80;
   localparam int QueueDepth = 2;
   localparam logic [31:0] MISS_MAX = 32'hFFFF_FFFF;

   typedef logic [FrameLen-1:0][7:0] window_type;

   // one burst outcome, frame bytes 1 to 10, byte 1 in the top byte
   typedef struct packed {
      logic                 found;
      logic [FieldBits-1:0] fields;
   } result_type;

   typedef struct packed {
      logic not_full;
      logic not_empty;
   } queue_status_type;

endpackage

// ===== rtl/asff_front.sv =====
module asff_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_rx_byte,
   input  logic                   req_burst_end,
   input  asff_pkg::queue_status_type q_status,
   output logic                   push,
   output asff_pkg::result_type   push_data
);
   import asff_pkg::*;

   window_type window_ff, window_in;
   logic [5:0] count_ff, count_in;
   logic overrun_ff, overrun_in;
   logic match_ff, match_in;
   logic [FieldBits-1:0] latched_ff, latched_in;
   logic accept;
   logic hit;
   logic [7:0] pair_sum [6];
   logic [7:0] quad_sum [3];
   logic [7:0] frame_sum;
   logic [FieldBits-1:0] frame_fields;

   assign req_ready = q_status.not_full;
   assign accept = req_valid & req_ready;

   always_comb begin
      // index 0 is the oldest byte
      for (int i = 0; i < FrameLen - 1; i++) begin
         window_in[i] = window_ff[i+1];
      end
      window_in[FrameLen-1] = req_rx_byte;
      for (int i = 0; i < 6; i++) begin
         pair_sum[i] = window_in[2*i] + window_in[2*i+1];
      end
      for (int i = 0; i < 3; i++) begin
         quad_sum[i] = pair_sum[2*i] + pair_sum[2*i+1];
      end
      frame_sum = quad_sum[0] + quad_sum[1] + quad_sum[2];
      for (int i = 0; i < 10; i++) begin
         frame_fields[FieldBits-1-8*i -: 8] = window_in[i+1];
      end

      count_in = (count_ff < COUNT_MAX) ? count_ff + 6'd1 : count_ff;
      overrun_in = overrun_ff | (count_in > BURST_DEPTH);
      hit = !overrun_in && !match_ff && (count_in >= FRAME_LEN_CNT) &&
            (window_in[0] == FRAME_HEADER) && (frame_sum == 8'd0);
      match_in = match_ff | hit;
      latched_in = hit ? frame_fields : latched_ff;

      push = accept & req_burst_end & ~overrun_in;
      push_data.found = match_in;
      push_data.fields = match_in ? latched_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         overrun_ff <= 1'b0;
         match_ff <= 1'b0;
      end else if (accept) begin
         if (req_burst_end) begin
            count_ff <= '0;
            overrun_ff <= 1'b0;
            match_ff <= 1'b0;
         end else begin
            count_ff <= count_in;
            overrun_ff <= overrun_in;
            match_ff <= match_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
         latched_ff <= latched_in;
      end
   end

endmodule

// ===== rtl/asff_queue.sv =====
module asff_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  asff_pkg::result_type      push_data,
   input  logic                      pop,
   output asff_pkg::result_type      head,
   output asff_pkg::queue_status_type status
);
   import asff_pkg::*;

   result_type entry_ff [QueueDepth];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff, fill_in;
   logic do_push, do_pop;

   assign status.not_full = (fill_ff != 2'(QueueDepth));
   assign status.not_empty = (fill_ff != 2'd0);
   assign do_push = push & status.not_full;
   assign do_pop = pop & status.not_empty;
   assign head = entry_ff[rd_ptr_ff];

   always_comb begin
      fill_in = fill_ff;
      case ({do_push, do_pop})
         2'b10: fill_in = fill_ff + 2'd1;
         2'b01: fill_in = fill_ff - 2'd1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/asff_back.sv =====
module asff_back (
   input  logic                      clock,
   input  logic                      reset,
   input  asff_pkg::result_type      head,
   input  asff_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_frame_found,
   output logic [15:0]               rsp_voc_level,
   output logic [15:0]               rsp_formaldehyde_level,
   output logic [15:0]               rsp_co2_equivalent,
   output logic signed [15:0]        rsp_temperature_tenths,
   output logic [15:0]               rsp_humidity_tenths,
   output logic [31:0]               rsp_fail_count
);
   import asff_pkg::*;

   logic valid_ff;
   result_type out_ff;
   logic [31:0] miss_ff, miss_in;

   assign pop = q_status.not_empty & (~valid_ff | rsp_ready);

   always_comb begin
      miss_in = miss_ff;
      if (!head.found && miss_ff != MISS_MAX) begin
         miss_in = miss_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         miss_ff <= '0;
      end else begin
         if (pop) begin
            valid_ff <= 1'b1;
            miss_ff <= miss_in;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= head;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_frame_found = out_ff.found;
   assign rsp_voc_level = out_ff.fields[79:64];
   assign rsp_formaldehyde_level = out_ff.fields[63:48];
   assign rsp_co2_equivalent = out_ff.fields[47:32];
   assign rsp_temperature_tenths = signed'(out_ff.fields[31:16]);
   assign rsp_humidity_tenths = out_ff.fields[15:0];
   assign rsp_fail_count = miss_ff;

endmodule

// ===== rtl/air_sensor_frame_finder_top.sv =====
// channel | direction | fields
// req     | in        | rx_byte, burst_end
// rsp     | out       | frame_found, voc, hcho, eco2, temperature, humidity, fail_count
//
// One byte accepted per cycle while req_ready is high; the 12-byte checksum is a
// combinational adder tree. A result passes from the burst's last byte through a
// two-entry queue and then the output register.
// req_ready drops only when the queue is full behind a stalled result.
// Synchronous reset clears burst state, queue, output valid and fail count.
module air_sensor_frame_finder_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   input  logic               req_burst_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_frame_found,
   output logic [15:0]        rsp_voc_level,
   output logic [15:0]        rsp_formaldehyde_level,
   output logic [15:0]        rsp_co2_equivalent,
   output logic signed [15:0] rsp_temperature_tenths,
   output logic [15:0]        rsp_humidity_tenths,
   output logic [31:0]        rsp_fail_count
);
   import asff_pkg::*;

   queue_status_type q_status;
   logic push, pop;
   result_type push_data, head;

   asff_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .req_burst_end (req_burst_end),
      .q_status      (q_status),
      .push          (push),
      .push_data     (push_data)
   );

   asff_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   asff_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .head                   (head),
      .q_status               (q_status),
      .pop                    (pop),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_frame_found        (rsp_frame_found),
      .rsp_voc_level          (rsp_voc_level),
      .rsp_formaldehyde_level (rsp_formaldehyde_level),
      .rsp_co2_equivalent     (rsp_co2_equivalent),
      .rsp_temperature_tenths (rsp_temperature_tenths),
      .rsp_humidity_tenths    (rsp_humidity_tenths),
      .rsp_fail_count         (rsp_fail_count)
   );

endmodule

// ===== rtl/asff_checker.sv =====
`include "air_sensor_frame_finder_top_macros.svh"

module asff_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_frame_found,
   input logic [15:0]        rsp_voc_level,
   input logic [15:0]        rsp_formaldehyde_level,
   input logic [15:0]        rsp_co2_equivalent,
   input logic signed [15:0] rsp_temperature_tenths,
   input logic [15:0]        rsp_humidity_tenths,
   input logic [31:0]        rsp_fail_count
);

   // stalled item holds
   `ASFF_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fail_count) && $stable(rsp_frame_found) && $stable(rsp_voc_level))

   // a miss carries zero data
   `ASFF_ASSERT(a_miss_zero, clock, reset, rsp_valid && !rsp_frame_found |-> rsp_voc_level == 16'd0 && rsp_formaldehyde_level == 16'd0 && rsp_co2_equivalent == 16'd0 && rsp_temperature_tenths == 16'sd0 && rsp_humidity_tenths == 16'd0)

   // input back-pressure only behind a waiting result
   `ASFF_ASSERT(a_ready_low, clock, reset, !req_ready |-> rsp_valid)

   // nothing shown straight after reset
   `ASFF_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !rsp_valid && req_ready)

endmodule

bind air_sensor_frame_finder_top asff_checker u_asff_checker (
   .clock                  (clock),
   .reset                  (reset),
   .req_ready              (req_ready),
   .rsp_valid              (rsp_valid),
   .rsp_ready              (rsp_ready),
   .rsp_frame_found        (rsp_frame_found),
   .rsp_voc_level          (rsp_voc_level),
   .rsp_formaldehyde_level (rsp_formaldehyde_level),
   .rsp_co2_equivalent     (rsp_co2_equivalent),
   .rsp_temperature_tenths (rsp_temperature_tenths),
   .rsp_humidity_tenths    (rsp_humidity_tenths),
   .rsp_fail_count         (rsp_fail_count)
);

// ===== verif/air_sensor_frame_finder_top_tb.sv =====
`timescale 1ns / 1ps

module air_sensor_frame_finder_top_tb;
   import asff_pkg::*;

   localparam int STALL_LIMIT = 1000;
   localparam int HOLD_CYCLES = 80;
   localparam int DRAIN_CYCLES = 20;
   localparam int IDLE_PCT = 17;
   localparam int RANDOM_ITEMS = 360;
   localparam int DIRECTED_ROWS = 25;

   typedef struct packed {
      logic        found;
      logic [15:0] voc;
      logic [15:0] hcho;
      logic [15:0] eco2;
      logic [15:0] temp;
      logic [15:0] humidity;
      logic [31:0] misses;
   } outcome_t;

   typedef struct packed {
      logic [7:0] rx;
      logic       last;
      logic       typed;
      outcome_t   want;
   } stim_row_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte = '0;
   logic               req_burst_end = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_frame_found;
   logic [15:0]        rsp_voc_level;
   logic [15:0]        rsp_formaldehyde_level;
   logic [15:0]        rsp_co2_equivalent;
   logic signed [15:0] rsp_temperature_tenths;
   logic [15:0]        rsp_humidity_tenths;
   logic [31:0]        rsp_fail_count;

   // frame search state
   window_type           scan_win = '0;
   logic [5:0]           scan_cnt = '0;
   logic                 scan_overrun = 1'b0;
   logic                 scan_latched = 1'b0;
   logic [FieldBits-1:0] scan_fields = '0;
   logic [31:0]          scan_misses = '0;

   outcome_t   burst_outcomes_q[$];
   logic [7:0] burst_q[$];
   stim_row_t  stim_rows[DIRECTED_ROWS];

   bit idle_on = 1'b1;
   bit hold_req = 1'b0;
   bit pressure_done = 1'b0;
   int bytes_sent = 0;
   int bursts_sent = 0;
   int outcomes_expected = 0;
   int found_bursts = 0;
   int missed_bursts = 0;
   int dropped_bursts = 0;
   int checked_outcomes = 0;
   int outcome_errors = 0;
   int quiet_cycles = 0;

   air_sensor_frame_finder_top i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_rx_byte            (req_rx_byte),
      .req_burst_end          (req_burst_end),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_frame_found        (rsp_frame_found),
      .rsp_voc_level          (rsp_voc_level),
      .rsp_formaldehyde_level (rsp_formaldehyde_level),
      .rsp_co2_equivalent     (rsp_co2_equivalent),
      .rsp_temperature_tenths (rsp_temperature_tenths),
      .rsp_humidity_tenths    (rsp_humidity_tenths),
      .rsp_fail_count         (rsp_fail_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_scan();
      scan_win = '0;
      scan_cnt = '0;
      scan_overrun = 1'b0;
      scan_latched = 1'b0;
      scan_fields = '0;
   endfunction

   // returns 1 when the byte closes a burst that yields an outcome
   function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                    output outcome_t res);
      logic [7:0] sum;
      int k;
      res = '0;
      sum = '0;
      scan_win = {scan_win[FrameLen-2:0], b};
      if (scan_cnt < COUNT_MAX) scan_cnt = scan_cnt + 6'd1;
      if (scan_cnt > BURST_DEPTH) scan_overrun = 1'b1;
      for (k = 0; k < FrameLen; k++) sum = sum + scan_win[k];
      if (!scan_overrun && !scan_latched && scan_cnt >= FRAME_LEN_CNT &&
          scan_win[FrameLen-1] == FRAME_HEADER && sum == 8'd0) begin
         scan_latched = 1'b1;
         scan_fields = scan_win[FrameLen-2:1];
      end
      if (!last) return 1'b0;
      bursts_sent++;
      if (scan_overrun) begin
         dropped_bursts++;
         clear_scan();
         return 1'b0;
      end
      if (scan_latched) found_bursts++;
      else missed_bursts++;
      if (!scan_latched && scan_misses != MISS_MAX) scan_misses = scan_misses + 32'd1;
      res = {scan_latched, scan_fields, scan_misses};
      clear_scan();
      return 1'b1;
   endfunction

   function automatic stim_row_t raw_row(input logic [7:0] b);
      return {b, 1'b0, 1'b0, outcome_t'('0)};
   endfunction

   function automatic stim_row_t known_row(input logic [7:0] b, input outcome_t want);
      return {b, 1'b1, 1'b1, want};
   endfunction

   task automatic drive_byte(input logic [7:0] b, input logic last, input logic typed,
                             input outcome_t want);
      outcome_t res;
      bit has;
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_burst_end <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      has = scan_byte(b, last, res);
      if (has) begin
         burst_outcomes_q.push_back(typed ? want : res);
         outcomes_expected++;
      end
   endtask

   function automatic void add_frame();
      logic [7:0] sum;
      logic [7:0] b;
      int k;
      sum = FRAME_HEADER;
      burst_q.push_back(FRAME_HEADER);
      for (k = 0; k < 10; k++) begin
         b = 8'($urandom);
         sum = sum + b;
         burst_q.push_back(b);
      end
      burst_q.push_back(8'd0 - sum);
   endfunction

   // noise rich in header bytes so that false starts occur
   function automatic void add_noise(input int n);
      repeat (n) burst_q.push_back(($urandom_range(3) == 0) ? FRAME_HEADER : 8'($urandom));
   endfunction

   task automatic send_burst();
      int k;
      for (k = 0; k < burst_q.size(); k++)
         drive_byte(burst_q[k], k == burst_q.size() - 1, 1'b0, '0);
      burst_q.delete();
   endtask

   task automatic random_burst();
      int kind;
      int pos;
      kind = $urandom_range(99);
      if (kind < 55) begin
         if ($urandom_range(2) == 0) add_noise($urandom_range(1, 8));
         add_frame();
         if ($urandom_range(3) == 0) add_frame();
         if ($urandom_range(2) == 0) add_noise($urandom_range(1, 4));
         if ($urandom_range(4) == 0) begin
            pos = $urandom_range(burst_q.size() - 1);
            burst_q[pos] = burst_q[pos] ^ (8'd1 << $urandom_range(7));
         end
      end else if (kind < 70) begin
         add_noise($urandom_range(1, FrameLen - 1));
      end else if (kind < 85) begin
         add_noise($urandom_range(FrameLen, int'(BURST_DEPTH)));
      end else if (kind < 93) begin
         // frame ending exactly at the depth limit or one byte past it
         add_noise(int'(BURST_DEPTH) - FrameLen + $urandom_range(1));
         add_frame();
      end else begin
         add_noise($urandom_range(0, 6));
         add_frame();
         add_noise($urandom_range(int'(BURST_DEPTH), 50));
      end
      send_burst();
   endtask

   // receiver
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      outcome_t got;
      outcome_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_frame_found, rsp_voc_level, rsp_formaldehyde_level, rsp_co2_equivalent,
                rsp_temperature_tenths, rsp_humidity_tenths, rsp_fail_count};
         checked_outcomes++;
         if (burst_outcomes_q.size() == 0) begin
            outcome_errors++;
            if (outcome_errors <= 10)
               $display("unexpected result %0d: found=%0b fails=%0d",
                        checked_outcomes, got.found, got.misses);
         end else begin
            want = burst_outcomes_q.pop_front();
            if (got.found !== want.found || got.voc !== want.voc ||
                got.hcho !== want.hcho || got.eco2 !== want.eco2 ||
                got.temp !== want.temp || got.humidity !== want.humidity ||
                got.misses !== want.misses) begin
               outcome_errors++;
               if (outcome_errors <= 10) begin
                  $display("result %0d exp: found=%0b voc=%h hcho=%h eco2=%h temp=%0d hum=%h fails=%0d",
                           checked_outcomes, want.found, want.voc, want.hcho, want.eco2,
                           $signed(want.temp), want.humidity, want.misses);
                  $display("result %0d got: found=%0b voc=%h hcho=%h eco2=%h temp=%0d hum=%h fails=%0d",
                           checked_outcomes, got.found, got.voc, got.hcho, got.eco2,
                           $signed(got.temp), got.humidity, got.misses);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("watchdog: %0d cycles with no item accepted", STALL_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int idx;
      int leftover;
      stim_rows = '{
         known_row(8'h2C, {1'b0, 80'h0, 32'd1}),
         raw_row(8'h2C),
         raw_row(8'h00), raw_row(8'h00), raw_row(8'h00), raw_row(8'h00), raw_row(8'h00),
         raw_row(8'h00), raw_row(8'h00), raw_row(8'h00), raw_row(8'h00), raw_row(8'h00),
         known_row(8'hD4, {1'b1, 80'h0, 32'd1}),
         raw_row(8'h2C),
         raw_row(8'hFF), raw_row(8'hFF), raw_row(8'hFF), raw_row(8'hFF), raw_row(8'hFF),
         raw_row(8'hFF), raw_row(8'hFF), raw_row(8'hFF), raw_row(8'hFF), raw_row(8'hFF),
         known_row(8'hDE, {1'b1, {80{1'b1}}, 32'd1})
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (idx = 0; idx < DIRECTED_ROWS; idx++)
         drive_byte(stim_rows[idx].rx, stim_rows[idx].last, stim_rows[idx].typed,
                    stim_rows[idx].want);

      while (bytes_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
         idle_on = !(bytes_sent > 150 && bytes_sent < 250);
         if (!pressure_done && bytes_sent > 300) begin
            // receiver stalls while one-byte bursts keep arriving
            hold_req = 1'b1;
            idle_on = 1'b0;
            repeat (20) begin
               burst_q.push_back(8'($urandom));
               send_burst();
            end
            pressure_done = 1'b1;
            idle_on = 1'b1;
         end
         random_burst();
      end
      req_valid <= 1'b0;

      while (burst_outcomes_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      leftover = burst_outcomes_q.size();

      $display("%0d bytes in %0d bursts: %0d with a frame, %0d without, %0d overlong dropped",
               bytes_sent, bursts_sent, found_bursts, missed_bursts, dropped_bursts);
      $display("%0d results expected, %0d checked, %0d mismatches, %0d outstanding",
               outcomes_expected, checked_outcomes, outcome_errors, leftover);
      if (outcome_errors == 0 && leftover == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
